// ===== rtl/ple_pkg.sv =====
package ple_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  // stream word widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [3:0] {
    M_INSERT  = 4'd0,
    M_DEL_POS = 4'd1,
    M_DEL_VAL = 4'd2,
    M_SEARCH  = 4'd3,
    M_MIDDLE  = 4'd4,
    M_NTH_END = 4'd5,
    M_REVERSE = 4'd6,
    M_SORT    = 4'd7,
    M_DEDUP   = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INSERT,
    C_DELETE,
    C_PREP,
    C_ROTATE,
    C_SWAP
  } cell_op_t;

  typedef enum logic [1:0] {
    SK_VALUE,
    SK_TAG,
    SK_FLAG
  } sort_kind_t;

  typedef struct packed {
    cell_op_t   op;
    sort_kind_t kind;
    logic       parity;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEL,
    ST_SORT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/ple_cell.sv =====
module ple_cell #(
  parameter int VW  = 32,
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  ple_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]     pos,
  input  logic [VW-1:0]     val,
  input  logic [CW-1:0]     count,
  input  logic [VW-1:0]     left_v,
  input  logic [IW-1:0]     left_t,
  input  logic              left_f,
  input  logic [VW-1:0]     right_v,
  input  logic [IW-1:0]     right_t,
  input  logic              right_f,
  output logic [VW-1:0]     v,
  output logic [IW-1:0]     t,
  output logic              f
);
  import ple_pkg::*;

  localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT  = CW'(IDX);
  localparam logic [CW-1:0] NXT_CNT = CW'(IDX + 1);
  localparam bit            HAS_LEFT = (IDX >= 1);

  logic [VW-1:0] v_next;
  logic [IW-1:0] t_next;
  logic          f_next;
  logic          is_left;
  logic          active;
  logic          swap;

  // compare-exchange with the partner of this round
  always_comb begin
    is_left = (MY_IDX[0] == cmd.parity);
    if (is_left) begin
      active = (NXT_CNT < count);
      case (cmd.kind)
        SK_VALUE: swap = ($signed(v) > $signed(right_v));
        SK_TAG:   swap = (t < right_t);
        SK_FLAG:  swap = f && !right_f;
        default:  swap = 1'b0;
      endcase
    end else begin
      active = HAS_LEFT && (MY_CNT < count);
      case (cmd.kind)
        SK_VALUE: swap = ($signed(left_v) > $signed(v));
        SK_TAG:   swap = (left_t < t);
        SK_FLAG:  swap = left_f && !f;
        default:  swap = 1'b0;
      endcase
    end
  end

  // next contents of the cell
  always_comb begin
    v_next = v;
    t_next = t;
    f_next = f;
    case (cmd.op)
      C_INSERT: begin
        if (MY_IDX == pos) v_next = val;
        else if (MY_IDX > pos) v_next = left_v;
      end
      C_DELETE: begin
        if (MY_IDX >= pos) v_next = right_v;
      end
      C_PREP: begin
        t_next = MY_IDX;
        f_next = HAS_LEFT && (MY_CNT < count) && (v == left_v);
      end
      C_ROTATE: begin
        v_next = right_v;
        t_next = right_t;
        f_next = right_f;
      end
      C_SWAP: begin
        if (active && swap) begin
          if (is_left) begin
            v_next = right_v;
            t_next = right_t;
            f_next = right_f;
          end else begin
            v_next = left_v;
            t_next = left_t;
            f_next = left_f;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    v <= v_next;
    t <= t_next;
    f <= f_next;
  end

endmodule

// ===== rtl/positional_list_engine.sv =====
// channel | dir | word                                  | accepted when
// s_*     | in  | mode[3:0] item_value[35:4] pos[42:36]  | s_tvalid && s_tready
// m_*     | out | ok[0] idx[6:1] value[38:7] len[45:39]  | m_tvalid && m_tready
// Insert, delete at position and rejected requests go from idle straight to done.
// Search, delete value, middle and nth from end rotate the cell ring once;
// a hit on delete value then passes through the delete state.
// Reverse and sort run CAPACITY odd-even rounds;
// dedup rotates the ring once and then runs the same rounds.
// rst clears the length and control; cell contents are undefined until written.
// One request at a time; a finished result waits while the result word is
// still held, which keeps s_tready low.
module positional_list_engine #(
  parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = ple_pkg::DEF_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ple_pkg::IN_DATA_W-1:0]   s_tdata,  // mode, item_value, position
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ple_pkg::OUT_DATA_W-1:0]  m_tdata   // ok, found_index, read_value, list_length
);
  import ple_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  // cell ring
  logic [VW-1:0] cv [CAPACITY];
  logic [IW-1:0] ct [CAPACITY];
  logic          cf [CAPACITY];

  cell_cmd_t     cmd;
  logic [IW-1:0] cmd_pos;

  // control and result registers
  state_t        state, state_next;
  mode_t         mode, mode_next;
  logic [VW-1:0] val, val_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] target, target_next;
  logic          hit, hit_next;
  logic [IW-1:0] fidx, fidx_next;
  logic [VW-1:0] rval, rval_next;
  logic          ok, ok_next;
  logic [CW-1:0] nflag, nflag_next;
  logic          out_load;

  // request decode
  mode_t         in_mode;
  logic [VW-1:0] in_val;
  logic [PW-1:0] pos_w, cnt_w;
  logic          k_live, k_last, match;

  assign in_mode = mode_t'(s_tdata[3:0]);
  assign in_val  = VW'($signed(s_tdata[35:4]));
  assign pos_w   = PW'(s_tdata[42:36]);
  assign cnt_w   = PW'(count);
  assign k_live  = (CW'(k) < count);
  assign k_last  = (k == IW'(CAPACITY - 1));
  assign match   = k_live && !hit && (cv[0] == val);

  assign s_tready = (state == ST_IDLE);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g + 1) % CAPACITY;
    ple_cell #(.VW(VW), .IDX(g), .IW(IW), .CW(CW)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pos     (cmd_pos),
      .val     (val_next),
      .count   (count),
      .left_v  (cv[L]),
      .left_t  (ct[L]),
      .left_f  (cf[L]),
      .right_v (cv[R]),
      .right_t (ct[R]),
      .right_f (cf[R]),
      .v       (cv[g]),
      .t       (ct[g]),
      .f       (cf[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    mode   <= mode_next;
    val    <= val_next;
    k      <= k_next;
    target <= target_next;
    hit    <= hit_next;
    fidx   <= fidx_next;
    rval   <= rval_next;
    ok     <= ok_next;
    nflag  <= nflag_next;
  end

  // sequencer
  always_comb begin
    state_next  = state;
    mode_next   = mode;
    val_next    = val;
    count_next  = count;
    k_next      = k;
    target_next = target;
    hit_next    = hit;
    fidx_next   = fidx;
    rval_next   = rval;
    ok_next     = ok;
    nflag_next  = nflag;
    cmd         = '{op: C_HOLD, kind: SK_VALUE, parity: k[0]};
    cmd_pos     = IW'(pos_w);
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          mode_next  = in_mode;
          val_next   = in_val;
          k_next     = '0;
          hit_next   = 1'b0;
          fidx_next  = '0;
          rval_next  = '0;
          ok_next    = 1'b0;
          nflag_next = '0;
          state_next = ST_DONE;
          case (in_mode)
            M_INSERT: begin
              if (pos_w <= cnt_w && count < CW'(CAPACITY)) begin
                cmd.op     = C_INSERT;
                count_next = count + 1'b1;
                ok_next    = 1'b1;
              end
            end
            M_DEL_POS: begin
              if (pos_w < cnt_w) begin
                cmd.op     = C_DELETE;
                count_next = count - 1'b1;
                ok_next    = 1'b1;
              end
            end
            M_DEL_VAL, M_SEARCH, M_DEDUP: begin
              cmd.op     = C_PREP;
              state_next = ST_SCAN;
            end
            M_MIDDLE: begin
              if (count != '0) begin
                target_next = IW'(count >> 1);
                state_next  = ST_SCAN;
              end
            end
            M_NTH_END: begin
              if (pos_w != '0 && pos_w <= cnt_w) begin
                target_next = IW'(cnt_w - pos_w);
                state_next  = ST_SCAN;
              end
            end
            M_REVERSE, M_SORT: begin
              cmd.op     = C_PREP;
              state_next = ST_SORT;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // entry k sits in cell 0 during this cycle
        cmd.op = C_ROTATE;
        k_next = k + 1'b1;
        if (match) begin
          hit_next  = 1'b1;
          fidx_next = k;
        end
        // only the read modes return an entry
        if (k == target && (mode inside {M_MIDDLE, M_NTH_END})) rval_next = cv[0];
        if (cf[0]) nflag_next = nflag + 1'b1;
        if (k_last) begin
          k_next = '0;
          case (mode)
            M_DEL_VAL: begin
              ok_next    = hit || match;
              state_next = (hit || match) ? ST_DEL : ST_DONE;
            end
            M_SEARCH: begin
              ok_next    = hit || match;
              state_next = ST_DONE;
            end
            M_DEDUP: state_next = ST_SORT;
            default: begin
              ok_next    = 1'b1;
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_DEL: begin
        cmd.op     = C_DELETE;
        cmd_pos    = fidx;
        count_next = count - 1'b1;
        state_next = ST_DONE;
      end
      ST_SORT: begin
        cmd.op = C_SWAP;
        case (mode)
          M_REVERSE: cmd.kind = SK_TAG;
          M_DEDUP:   cmd.kind = SK_FLAG;
          default:   cmd.kind = SK_VALUE;
        endcase
        k_next = k + 1'b1;
        if (k_last) begin
          if (mode == M_DEDUP) count_next = count - nflag;
          ok_next    = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[0]     <= ok;
      m_tdata[6:1]   <= (mode == M_SEARCH) ? 6'(fidx) : 6'd0;
      m_tdata[38:7]  <= 32'(rval);
      m_tdata[45:39] <= 7'(count);
      m_tdata[47:46] <= 2'b00;
    end
  end

endmodule

// ===== rtl/ple_checker.sv =====
module ple_checker #(
  parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ple_pkg::OUT_DATA_W-1:0] m_tdata
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // length never exceeds the store
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[45:39] <= 7'(CAPACITY)))
    else $error("length above capacity");

  // a failed request reports no index and no value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[38:1] == '0))
    else $error("failed request with payload");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

// ===== verif/positional_list_checker.sv =====
`timescale 1ns / 100ps

module positional_list_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [ple_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [ple_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                            fail_count,
  output int                            pending
);
  import ple_pkg::*;

  localparam int CAP = DEF_CAPACITY;

  typedef struct packed {
    logic [6:0]  len;
    logic [31:0] value;
    logic [5:0]  idx;
    logic        ok;
  } result_t;

  logic signed [31:0] list_mem [CAP];
  int                 list_len;
  result_t            result_q [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    fail_count++;
  endtask

  // apply one request to the shadow list and return its result word
  function automatic result_t apply_request(input logic [3:0] mode,
                                            input logic signed [31:0] v,
                                            input int pos);
    result_t r;
    int i, j;
    logic signed [31:0] t;
    r = '0;
    case (mode)
      M_INSERT: if (pos <= list_len && list_len < CAP) begin
        for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
        list_mem[pos] = v;
        list_len++;
        r.ok = 1;
      end
      M_DEL_POS: if (pos < list_len) begin
        for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
        r.ok = 1;
      end
      M_DEL_VAL, M_SEARCH: begin
        for (i = 0; i < list_len; i++) if (list_mem[i] == v) break;
        if (i < list_len) begin
          r.ok = 1;
          if (mode == M_SEARCH) r.idx = 6'(i);
          else begin
            for (j = i; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
            list_len--;
          end
        end
      end
      M_MIDDLE: if (list_len > 0) begin
        r.value = list_mem[list_len/2];
        r.ok = 1;
      end
      M_NTH_END: if (pos >= 1 && pos <= list_len) begin
        r.value = list_mem[list_len-pos];
        r.ok = 1;
      end
      M_REVERSE: begin
        for (i = 0, j = list_len; i + 1 < j; i++, j--) begin
          t = list_mem[i]; list_mem[i] = list_mem[j-1]; list_mem[j-1] = t;
        end
        r.ok = 1;
      end
      M_SORT: begin
        for (i = 1; i < list_len; i++) begin
          t = list_mem[i];
          for (j = i; j > 0 && list_mem[j-1] > t; j--) list_mem[j] = list_mem[j-1];
          list_mem[j] = t;
        end
        r.ok = 1;
      end
      M_DEDUP: begin
        if (list_len > 0) begin
          j = 1;
          for (i = 1; i < list_len; i++) begin
            if (list_mem[i] != list_mem[j-1]) begin
              list_mem[j] = list_mem[i];
              j++;
            end
          end
          list_len = j;
        end
        r.ok = 1;
      end
      default: ;
    endcase
    r.len = 7'(list_len);
    return r;
  endfunction

  // predict on accepted requests, compare accepted result words
  always @(posedge clk) begin
    result_t got, exp;
    if (rst) begin
      list_len   = 0;
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready)
        result_q.push_back(apply_request(s_tdata[3:0], $signed(s_tdata[35:4]),
                                         int'(s_tdata[42:36])));
      if (m_tvalid && m_tready) begin
        got = m_tdata[45:0];
        if (result_q.size() == 0) report("unexpected word", 32'(got.len), 32'd0);
        else begin
          exp = result_q.pop_front();
          if (got.ok !== exp.ok) report("ok", 32'(got.ok), 32'(exp.ok));
          if (got.idx !== exp.idx) report("found_index", 32'(got.idx), 32'(exp.idx));
          if (got.value !== exp.value) report("read_value", got.value, exp.value);
          if (got.len !== exp.len) report("list_length", 32'(got.len), 32'(exp.len));
        end
      end
    end
    pending = result_q.size();
  end
endmodule

// ===== verif/positional_list_engine_tb.sv =====
`timescale 1ns / 100ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int WATCHDOG = 20000;

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   s_tvalid = 0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  int                     fail_count;
  int                     pending;
  int                     idle_cycles;
  bit                     hold_off = 0;
  bit                     stim_done = 0;

  always #5 clk = ~clk;

  positional_list_engine dut (.*);

  positional_list_checker chk (.*);

  // offer one request word and wait until it is taken
  task automatic send_request(input logic [3:0] mode, input logic [31:0] v, input logic [6:0] pos);
    s_tdata  <= {5'd0, pos, v, mode};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      s_tvalid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  // receiver stall pattern with one long hold-off
  initial begin
    int k;
    k = 0;
    @(negedge clk);
    while (1) begin
      if (k == 300) begin
        hold_off = 1;
        m_tready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      m_tready <= (k % 40 < 20) ? 1'b1 : ($urandom_range(0, 2) != 0);
      k++;
      @(negedge clk);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [3:0] mode;
    int n;
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: empty-store cases, extremes, every operation
    send_request(M_MIDDLE, 0, 0);
    send_request(M_NTH_END, 0, 1);
    send_request(M_DEL_POS, 0, 0);
    send_request(M_REVERSE, 0, 0);
    send_request(M_SORT, 0, 0);
    send_request(M_DEDUP, 0, 0);
    send_request(M_INSERT, 32'h8000_0000, 1);
    send_request(M_INSERT, 32'h8000_0000, 0);
    send_request(M_INSERT, 32'h7fff_ffff, 1);
    send_request(M_INSERT, 32'h7fff_ffff, 0);
    send_request(M_INSERT, 5, 2);
    send_request(M_SEARCH, 5, 0);
    send_request(M_SEARCH, 6, 0);
    send_request(M_NTH_END, 0, 4);
    send_request(M_NTH_END, 0, 0);
    send_request(M_MIDDLE, 0, 0);
    send_request(M_SORT, 0, 0);
    send_request(M_DEL_VAL, 9, 0);
    send_request(M_DEL_VAL, 5, 0);
    send_request(M_DEL_POS, 0, 3);
    send_request(M_DEDUP, 0, 0);
    send_request(4'd9, 0, 0);
    send_request(4'd15, 32'hffff_ffff, 7'h7f);
    // fill to capacity, then overflow
    for (n = 0; n < 66; n++) send_request(M_INSERT, pick_value(), 0);
    send_request(M_SEARCH, 32'h8000_0000, 0);
    send_request(M_REVERSE, 0, 0);
    send_request(M_DEDUP, 0, 0);
    // random mix, biased toward inserts to keep the list populated
    for (n = 0; n < 1650; n++) begin
      case ($urandom_range(0, 19))
        0,1,2,3,4,5: mode = M_INSERT;
        6,7: mode = M_DEL_POS;
        8,9: mode = M_DEL_VAL;
        10,11: mode = M_SEARCH;
        12: mode = M_MIDDLE;
        13,14: mode = M_NTH_END;
        15: mode = M_REVERSE;
        16: mode = M_SORT;
        17: mode = M_DEDUP;
        18: mode = 4'($urandom_range(9, 15));
        default: mode = 4'($urandom_range(0, 8));
      endcase
      send_request(mode, pick_value(),
                   ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, 66)));
      gap();
    end
    s_tvalid <= 0;
    stim_done = 1;
    n = 0;
    while (pending != 0 && n < WATCHDOG) begin
      @(negedge clk);
      n++;
    end
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
rtl/ple_checker.sv
verif/positional_list_checker.sv
verif/positional_list_engine_tb.sv
